// ===== sv/por_pkg.sv =====
`timescale 1ns / 1ps

package por_pkg;

  // default frame buffer size in pixels
  localparam int ScreenWidth  = 256;
  localparam int ScreenHeight = 256;

  // request codes
  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // configuration register indexes
  localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
  localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [23:0]        color;
    logic               shape_start;
    logic               shape_end;
  } cmd_t;

  typedef struct packed {
    logic [23:0] read_color;
    logic        is_read_data;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_DRAW,
    ST_NEXT,
    ST_ACK,
    ST_RDOUT
  } state_t;

endpackage

// ===== sv/polygon_outline_rasterizer.sv =====
`timescale 1ns / 1ps

// channel   | signals                              | transaction
// ----------+--------------------------------------+-------------------------------
// command   | start, busy, cmd                     | start high while busy low
// result    | done, result                         | one cycle strobe on done
// config    | cfg_valid, cfg_ready, cfg_index/data | cfg_valid and cfg_ready high
//
// a read passes through the RDOUT state. a vertex is accepted in IDLE and acknowledged in ACK,
// and for each segment passes the SETUP state, (major axis length + 1) pixels in DRAW through
// the shared step unit (one add and compare-subtract of the error term), none for a zero-length
// segment, and the NEXT hand-over; the first vertex of a shape draws no segment and passes NEXT.
// after reset a clearing pass writes zeros to all SCREEN_WIDTH * SCREEN_HEIGHT entries
// of the frame buffer; busy stays high meanwhile. config is always accepted.
// the receiver cannot stall: a result shows for exactly one cycle.
module polygon_outline_rasterizer #(
  parameter int SCREEN_WIDTH  = por_pkg::ScreenWidth,
  parameter int SCREEN_HEIGHT = por_pkg::ScreenHeight
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  por_pkg::cmd_t    cmd,
  output logic             done,
  output por_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [8:0]       cfg_data
);

  localparam int Depth = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);

  por_pkg::state_t state, state_next;

  logic [8:0] active_width, active_height;

  logic [23:0] mem [Depth];
  logic [23:0] rd_data;
  logic        rd_ok;

  logic [AW-1:0] clr_addr;

  // shape state
  logic signed [15:0] first_x, first_y, prev_x, prev_y;
  logic               in_shape;
  logic signed [15:0] vx, vy;
  logic [23:0]        vcolor;
  logic               pend_close;

  // segment ends
  logic signed [15:0] seg_ax, seg_ay, seg_bx, seg_by;

  // stepping registers
  logic               maj_x;
  logic [15:0]        len, amin, k;
  logic [16:0]        err;
  logic               neg_maj, neg_min;
  logic signed [17:0] cur_maj, cur_min;

  // setup arithmetic
  logic signed [16:0] dx, dy;
  logic [15:0]        adx, ady;
  logic               setup_maj_x, setup_zero;

  always_comb begin
    dx          = 17'(seg_bx) - 17'(seg_ax);
    dy          = 17'(seg_by) - 17'(seg_ay);
    adx         = dx[16] ? 16'(-dx) : 16'(dx);
    ady         = dy[16] ? 16'(-dy) : 16'(dy);
    setup_maj_x = ady < adx;
    setup_zero  = !setup_maj_x && (ady == 16'd0);
  end

  // shared step unit: error add and compare-subtract
  logic [16:0] err_sum;
  logic        err_wrap;
  logic        last_pix;

  always_comb begin
    err_sum  = err + 17'(amin);
    err_wrap = err_sum >= 17'(len);
    last_pix = k == len;
  end

  // clip and address
  logic signed [17:0] lim_w, lim_h;
  logic signed [17:0] px, py;
  logic               px_on;
  logic [AW-1:0]      draw_addr;
  logic signed [17:0] rx, ry;
  logic               rd_on;
  logic [AW-1:0]      rd_addr;

  always_comb begin
    lim_w = (18'(active_width) < 18'(SCREEN_WIDTH)) ? 18'(active_width) : 18'(SCREEN_WIDTH);
    lim_h = (18'(active_height) < 18'(SCREEN_HEIGHT)) ? 18'(active_height)
                                                        : 18'(SCREEN_HEIGHT);
    px    = maj_x ? cur_maj : cur_min;
    py    = maj_x ? cur_min : cur_maj;
    px_on = !px[17] && !py[17] && (px < lim_w) && (py < lim_h);
    draw_addr = AW'(AW'(py[YW-1:0]) * AW'(SCREEN_WIDTH)) + AW'(px[XW-1:0]);
    rx    = 18'(cmd.x);
    ry    = 18'(cmd.y);
    rd_on = !rx[17] && !ry[17] && (rx < lim_w) && (ry < lim_h);
    rd_addr = AW'(AW'(ry[YW-1:0]) * AW'(SCREEN_WIDTH)) + AW'(rx[XW-1:0]);
  end

  // frame buffer write port
  logic          we;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata;

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = 24'd0;
    if (state == por_pkg::ST_CLEAR) begin
      we = 1'b1;
    end else if (state == por_pkg::ST_DRAW) begin
      we    = px_on;
      waddr = draw_addr;
      wdata = vcolor;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      por_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(Depth - 1)) state_next = por_pkg::ST_IDLE;
      end
      por_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd.req_type == por_pkg::REQ_READ) state_next = por_pkg::ST_RDOUT;
          else if (cmd.shape_start || !in_shape) state_next = por_pkg::ST_NEXT;
          else state_next = por_pkg::ST_SETUP;
        end
      end
      por_pkg::ST_SETUP: state_next = setup_zero ? por_pkg::ST_NEXT : por_pkg::ST_DRAW;
      por_pkg::ST_DRAW: begin
        if (last_pix) state_next = por_pkg::ST_NEXT;
      end
      por_pkg::ST_NEXT: state_next = pend_close ? por_pkg::ST_SETUP : por_pkg::ST_ACK;
      por_pkg::ST_ACK:   state_next = por_pkg::ST_IDLE;
      por_pkg::ST_RDOUT: state_next = por_pkg::ST_IDLE;
      default:           state_next = por_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy                = state != por_pkg::ST_IDLE;
    done                = 1'b0;
    result.read_color   = 24'd0;
    result.is_read_data = 1'b0;
    case (state)
      por_pkg::ST_ACK: done = 1'b1;
      por_pkg::ST_RDOUT: begin
        done                = 1'b1;
        result.is_read_data = 1'b1;
        result.read_color   = rd_ok ? rd_data : 24'd0;
      end
      default: done = 1'b0;
    endcase
  end

  assign cfg_ready = 1'b1;

  // control state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= por_pkg::ST_CLEAR;
      clr_addr      <= '0;
      active_width  <= 9'd256;
      active_height <= 9'd256;
      first_x       <= '0;
      first_y       <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      in_shape      <= 1'b0;
      pend_close    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == por_pkg::CFG_ACTIVE_WIDTH) active_width <= cfg_data;
        else active_height <= cfg_data;
      end
      if (state == por_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == por_pkg::ST_IDLE && start && cmd.req_type == por_pkg::REQ_VERTEX) begin
        if (cmd.shape_start || !in_shape) begin
          first_x <= cmd.x;
          first_y <= cmd.y;
        end
        prev_x     <= cmd.x;
        prev_y     <= cmd.y;
        in_shape   <= !cmd.shape_end;
        pend_close <= cmd.shape_end;
      end
      if (state == por_pkg::ST_NEXT) pend_close <= 1'b0;
    end
  end

  // payload and stepping registers
  always_ff @(posedge clk) begin
    case (state)
      por_pkg::ST_IDLE: begin
        rd_ok  <= rd_on;
        vx     <= cmd.x;
        vy     <= cmd.y;
        vcolor <= cmd.color;
        seg_ax <= prev_x;
        seg_ay <= prev_y;
        seg_bx <= cmd.x;
        seg_by <= cmd.y;
      end
      por_pkg::ST_NEXT: begin
        // closing segment back to the first vertex
        seg_ax <= vx;
        seg_ay <= vy;
        seg_bx <= first_x;
        seg_by <= first_y;
      end
      por_pkg::ST_SETUP: begin
        maj_x   <= setup_maj_x;
        len     <= setup_maj_x ? adx : ady;
        amin    <= setup_maj_x ? ady : adx;
        neg_maj <= setup_maj_x ? dx[16] : dy[16];
        neg_min <= setup_maj_x ? dy[16] : dx[16];
        cur_maj <= setup_maj_x ? 18'(seg_ax) : 18'(seg_ay);
        cur_min <= setup_maj_x ? 18'(seg_ay) : 18'(seg_ax);
        k       <= '0;
        err     <= '0;
      end
      por_pkg::ST_DRAW: begin
        k       <= k + 16'd1;
        cur_maj <= neg_maj ? cur_maj - 18'sd1 : cur_maj + 18'sd1;
        if (err_wrap) begin
          err     <= err_sum - 17'(len);
          cur_min <= neg_min ? cur_min - 18'sd1 : cur_min + 18'sd1;
        end else begin
          err <= err_sum;
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

endmodule
